FILE: sv/ise_pkg.sv
// Shared types, constants and helpers for the integer set engine.
// No dependencies; every other file refers to it by scoped names.
package ise_pkg;

	localparam int SET_CAPACITY = 32;
	localparam int VALUE_WIDTH  = 32;
	localparam int IDX_W        = $clog2(SET_CAPACITY);
	localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
	localparam int IN_W         = 32;
	localparam int OUT_W        = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_PROBE  = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_ADDED     = 4'd0,
		ST_PRESENT   = 4'd1,
		ST_FULL      = 4'd2,
		ST_REMOVED   = 4'd3,
		ST_ABSENT    = 4'd4,
		ST_MEMBER    = 4'd5,
		ST_NONMEMBER = 4'd6,
		ST_ITEM      = 4'd7,
		ST_EMPTY     = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXEC
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch_in;
		logic compare;
		logic exec;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_list;
		logic list_done;
	} stat_t;

	// lowest set bit position (zero when none set)
	function automatic logic [IDX_W-1:0] first_set(input logic [SET_CAPACITY-1:0] vec);
		logic [IDX_W-1:0] pos;
		pos = '0;
		for (int i = SET_CAPACITY - 1; i >= 0; i--) begin
			if (vec[i]) begin
				pos = IDX_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

FILE: sv/ise_ctrl.sv
// Sequencer for the integer set engine: accept, compare, execute/list.
// Depends on ise_pkg; drives cmd_t to ise_datapath, reads stat_t back.
module ise_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output ise_pkg::cmd_t   cmd,
	input  ise_pkg::stat_t  stat
);

	ise_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ise_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ise_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ise_pkg::S_CMP;
				end
			end
			ise_pkg::S_CMP: begin
				cmd.compare = 1'b1;
				state_d     = ise_pkg::S_EXEC;
			end
			ise_pkg::S_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					if (!stat.is_list || stat.list_done) begin
						state_d = ise_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = ise_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/ise_datapath.sv
// Entry store, parallel match, delete shifter, list walker and output word.
// Depends on ise_pkg; steered by ise_ctrl through cmd_t.
module ise_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ise_pkg::cmd_t        cmd,
	output ise_pkg::stat_t       stat,
	input  logic [1:0]           opcode,
	input  logic signed [31:0]   value,
	input  logic                 unmarked_only,
	output logic [3:0]           status,
	output logic signed [31:0]   value_res,
	output logic                 last
);

	localparam int CAP = ise_pkg::SET_CAPACITY;
	localparam int VW  = ise_pkg::VALUE_WIDTH;
	localparam int IW  = ise_pkg::IDX_W;
	localparam int CW  = ise_pkg::CNT_W;

	// latched input word
	ise_pkg::op_t                    op_q;
	logic signed [ise_pkg::IN_W-1:0] raw_q;
	logic                            only_q;

	// set state
	logic [VW-1:0]  ent_q [CAP];
	logic [CAP-1:0] valid_q;
	logic [CAP-1:0] mark_q;
	logic [CW-1:0]  count_q;

	// compare results
	logic           hit_q;
	logic [IW-1:0]  pos_q;
	logic [CAP-1:0] rem_q;

	// output payload
	ise_pkg::status_t         status_q;
	logic [ise_pkg::OUT_W-1:0] res_q;
	logic                     last_q;

	logic [VW-1:0]  v_ext;
	logic [CAP-1:0] match;
	logic [CAP-1:0] lo_mask;
	logic [CAP-1:0] rem_rest;
	logic [IW-1:0]  rem_pos;
	logic [IW-1:0]  ins_idx;
	logic           full;
	logic           rem_last;
	logic           do_ins;
	logic           do_del;
	logic           do_probe;
	logic           do_list;
	logic           list_end;

	assign v_ext = VW'(raw_q);

	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			match[i] = valid_q[i] && (ent_q[i] == v_ext);
		end
	end

	assign full     = count_q == CW'(CAP);
	assign ins_idx  = count_q[IW-1:0];
	assign lo_mask  = (CAP'(1) << pos_q) - CAP'(1);
	assign rem_pos  = ise_pkg::first_set(rem_q);
	assign rem_rest = rem_q & ~(CAP'(1) << rem_pos);
	assign rem_last = (rem_q != '0) && (rem_rest == '0);

	assign do_ins   = cmd.exec && op_q == ise_pkg::OP_INSERT && !hit_q && !full;
	assign do_del   = cmd.exec && op_q == ise_pkg::OP_DELETE && hit_q;
	assign do_probe = cmd.exec && op_q == ise_pkg::OP_PROBE && hit_q;
	assign do_list  = cmd.exec && op_q == ise_pkg::OP_LIST;
	assign list_end = do_list && (rem_q == '0 || rem_last);

	assign stat.is_list   = op_q == ise_pkg::OP_LIST;
	assign stat.list_done = (rem_q == '0) || rem_last;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q   <= ise_pkg::op_t'(opcode);
			raw_q  <= value;
			only_q <= unmarked_only;
		end
		if (cmd.compare) begin
			hit_q <= |match;
			pos_q <= ise_pkg::first_set(match);
			rem_q <= valid_q & ~(only_q ? mark_q : '0);
		end else if (do_list) begin
			rem_q <= rem_rest;
		end
		if (do_ins) begin
			ent_q[ins_idx] <= v_ext;
		end
		if (do_del) begin
			for (int i = 0; i < CAP - 1; i++) begin
				if (IW'(i) >= pos_q) begin
					ent_q[i] <= ent_q[i + 1];
				end
			end
		end
	end

	// control state of the set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			mark_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_ins) begin
				valid_q[ins_idx] <= 1'b1;
				mark_q[ins_idx]  <= 1'b0;
				count_q          <= count_q + CW'(1);
			end else if (do_del) begin
				// shift everything at and above the hit down by one
				valid_q <= (valid_q & lo_mask) | ({1'b0, valid_q[CAP-1:1]} & ~lo_mask);
				mark_q  <= (mark_q & lo_mask) | ({1'b0, mark_q[CAP-1:1]} & ~lo_mask);
				count_q <= count_q - CW'(1);
			end else if (do_probe) begin
				mark_q[pos_q] <= 1'b1;
			end else if (list_end) begin
				mark_q <= '0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			last_q <= 1'b1;
			res_q  <= ise_pkg::OUT_W'(raw_q);
			case (op_q)
				ise_pkg::OP_INSERT: begin
					if (hit_q) begin
						status_q <= ise_pkg::ST_PRESENT;
					end else if (full) begin
						status_q <= ise_pkg::ST_FULL;
					end else begin
						status_q <= ise_pkg::ST_ADDED;
					end
				end
				ise_pkg::OP_DELETE: begin
					status_q <= hit_q ? ise_pkg::ST_REMOVED : ise_pkg::ST_ABSENT;
				end
				ise_pkg::OP_PROBE: begin
					status_q <= hit_q ? ise_pkg::ST_MEMBER : ise_pkg::ST_NONMEMBER;
				end
				ise_pkg::OP_LIST: begin
					if (rem_q == '0) begin
						status_q <= ise_pkg::ST_EMPTY;
					end else begin
						status_q <= ise_pkg::ST_ITEM;
						res_q    <= ise_pkg::OUT_W'(ent_q[rem_pos]);
						last_q   <= rem_last;
					end
				end
				default: begin
					status_q <= ise_pkg::ST_EMPTY;
				end
			endcase
		end
	end

	assign status    = status_q;
	assign value_res = res_q;
	assign last      = last_q;

endmodule

FILE: sv/integer_set_engine_core.sv
// Top level of the integer set engine: controller plus datapath.
// Depends on ise_pkg, ise_ctrl and ise_datapath.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one word: opcode, value,
//    unmarked_only. Insert, delete and probe each give one result word;
//    list gives one word per emitted entry (or one empty word), the final
//    one with last set.
//  - Output channel (out_valid/out_ready) carries status, value_res, last.
//  - A word is accepted in idle, compared against all entries in
//    the next cycle, and its first result is loaded into the output
//    register in execute once that register is free.
//  - Each word runs through the accept / compare / execute sequence of the
//    controller before the next is accepted, with the 32-way match
//    registered between compare and execute; a list stays in execute
//    until it has issued one result per emitted entry.
//  - in_ready is high in idle even while a result waits in the output
//    register, so the next word is taken and compared; execute then holds
//    until the receiver frees the output register.
//  - Receiver stall: out_valid and the payload hold until out_ready.
//  - Reset (arst_n low) empties the set and clears all marks at once.
module integer_set_engine_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          opcode,
	input  logic signed [31:0]  value,
	input  logic                unmarked_only,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          status,
	output logic signed [31:0]  value_res,
	output logic                last
);

	ise_pkg::cmd_t  cmd;
	ise_pkg::stat_t stat;

	// sequencing: owns the state and the output valid flag
	ise_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// storage, match, update and the output payload register
	ise_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.opcode        (opcode),
		.value         (value),
		.unmarked_only (unmarked_only),
		.status        (status),
		.value_res     (value_res),
		.last          (last)
	);

endmodule

FILE: tb/tb_integer_set_engine_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_set_engine_core: directed and random commands,
// an in-file set model that predicts every result word. Depends on ise_pkg and the core.
module tb_integer_set_engine_core;

	localparam int POOL_SIZE   = 48;   // more values than slots, so the set fills up
	localparam int HOLD_CYCLES = 300;  // long receiver hold-off in the last phase
	localparam int STALL_LIMIT = 4000; // cycles with no handshake before giving up
	localparam int RAND_PER_PHASE = 103;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          opcode;
	logic signed [31:0]  value;
	logic                unmarked_only;
	logic                out_valid;
	logic                out_ready;
	logic [3:0]          status;
	logic signed [31:0]  value_res;
	logic                last;

	int unsigned in_idle_pct;
	int unsigned out_idle_pct;
	bit          hold_req;
	int          stall_cycles;
	logic [31:0] value_pool [POOL_SIZE];

	typedef struct {
		ise_pkg::status_t code;
		logic [31:0]      word;
		logic             fin;
	} set_reply_t;

	// Tracks the set contents and marks, and queues the reply words each command causes.
	class set_scoreboard;
		logic [ise_pkg::VALUE_WIDTH-1:0] keys [ise_pkg::SET_CAPACITY];
		bit                              marks [ise_pkg::SET_CAPACITY];
		int                              count;
		set_reply_t                      pending_replies [$];
		int                              errors;

		function new();
			count = 0;
			errors = 0;
			foreach (marks[i]) marks[i] = 1'b0;
		endfunction

		function int pending();
			return pending_replies.size();
		endfunction

		function void push_reply(ise_pkg::status_t code, logic [31:0] word, logic fin);
			set_reply_t r;
			r.code = code;
			r.word = word;
			r.fin  = fin;
			pending_replies.push_back(r);
		endfunction

		function int find_key(logic [ise_pkg::VALUE_WIDTH-1:0] k);
			for (int i = 0; i < count; i++) begin
				if (keys[i] == k) return i;
			end
			return -1;
		endfunction

		// Accepted command word: update the set and queue its replies.
		function void note_command(ise_pkg::op_t op, logic [31:0] raw, bit only);
			logic [63:0]                     wide;
			logic [ise_pkg::VALUE_WIDTH-1:0] k;
			int                              pos;
			int                              emitted;
			wide = {{32{raw[31]}}, raw};
			k = wide[ise_pkg::VALUE_WIDTH-1:0];
			pos = find_key(k);
			case (op)
				ise_pkg::OP_INSERT: begin
					if (pos >= 0) begin
						push_reply(ise_pkg::ST_PRESENT, raw, 1'b1);
					end else if (count >= ise_pkg::SET_CAPACITY) begin
						push_reply(ise_pkg::ST_FULL, raw, 1'b1);
					end else begin
						keys[count] = k;
						marks[count] = 1'b0;
						count++;
						push_reply(ise_pkg::ST_ADDED, raw, 1'b1);
					end
				end
				ise_pkg::OP_DELETE: begin
					if (pos < 0) begin
						push_reply(ise_pkg::ST_ABSENT, raw, 1'b1);
					end else begin
						// close the gap; marks travel with their entries
						for (int i = pos; i + 1 < count; i++) begin
							keys[i] = keys[i + 1];
							marks[i] = marks[i + 1];
						end
						count--;
						marks[count] = 1'b0;
						push_reply(ise_pkg::ST_REMOVED, raw, 1'b1);
					end
				end
				ise_pkg::OP_PROBE: begin
					if (pos >= 0) begin
						marks[pos] = 1'b1;
						push_reply(ise_pkg::ST_MEMBER, raw, 1'b1);
					end else begin
						push_reply(ise_pkg::ST_NONMEMBER, raw, 1'b1);
					end
				end
				default: begin
					emitted = 0;
					for (int i = 0; i < count; i++) begin
						if (!(only && marks[i])) begin
							push_reply(ise_pkg::ST_ITEM, 32'(keys[i]), 1'b0);
							emitted++;
						end
					end
					if (emitted == 0) push_reply(ise_pkg::ST_EMPTY, raw, 1'b1);
					else pending_replies[pending_replies.size() - 1].fin = 1'b1;
					foreach (marks[i]) marks[i] = 1'b0;
				end
			endcase
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10) $display("%0t ns: %s", $realtime, msg);
		endfunction

		// Accepted result word: compare with the oldest expected reply.
		function void check_reply(logic [3:0] got_code, logic [31:0] got_word, logic got_fin);
			set_reply_t exp_r;
			if (pending_replies.size() == 0) begin
				report($sformatf("unexpected result word: status %0d value %h last %b",
					got_code, got_word, got_fin));
				return;
			end
			exp_r = pending_replies.pop_front();
			if (got_code !== exp_r.code)
				report($sformatf("status: expected %0d, got %0d", exp_r.code, got_code));
			if (got_word !== exp_r.word)
				report($sformatf("value_res: expected %h, got %h", exp_r.word, got_word));
			if (got_fin !== exp_r.fin)
				report($sformatf("last: expected %b, got %b", exp_r.fin, got_fin));
		endfunction
	endclass

	set_scoreboard board;

	integer_set_engine_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.value         (value),
		.unmarked_only (unmarked_only),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.value_res     (value_res),
		.last          (last)
	);

	always #1 clk = ~clk;

	// Offer one command word and wait for the handshake. Returns at the accepting edge,
	// so the next call can keep in_valid high without dropping it.
	task automatic send_word(ise_pkg::op_t op, logic [31:0] v, bit only);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_valid      <= 1'b1;
		opcode        <= op;
		value         <= v;
		unmarked_only <= only;
		do @(posedge clk); while (!in_ready);
		board.note_command(op, v, only);
	endtask

	// Mostly values from a shared pool so inserts, deletes and probes hit each other;
	// insert weighted above delete so the set hovers around full.
	task automatic send_random(int n);
		int unsigned  r;
		ise_pkg::op_t op;
		logic [31:0]  v;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 45) op = ise_pkg::OP_INSERT;
			else if (r < 65) op = ise_pkg::OP_DELETE;
			else if (r < 85) op = ise_pkg::OP_PROBE;
			else op = ise_pkg::OP_LIST;
			v = ($urandom_range(9) == 0) ? $urandom() : value_pool[$urandom_range(POOL_SIZE - 1)];
			send_word(op, v, 1'($urandom_range(1)));
		end
	endtask

	// Result side: checks every accepted word and throttles out_ready.
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) board.check_reply(status, value_res, last);
			if (hold_req) begin
				// long hold-off: the output register stays full and the core must stall its input
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	// Watchdog: no handshake on either channel for too long ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL integer_set_engine_core");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		opcode        = ise_pkg::OP_INSERT;
		value         = '0;
		unmarked_only = 1'b0;
		out_ready     = 1'b0;
		hold_req      = 1'b0;
		stall_cycles  = 0;
		in_idle_pct   = 32;
		out_idle_pct  = 73;
		board = new();

		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty lists, extremes, duplicates, marks moving on delete
		send_word(ise_pkg::OP_LIST,   32'h1234_5678, 1'b0);  // empty set
		send_word(ise_pkg::OP_LIST,   32'hffff_ffff, 1'b1);
		send_word(ise_pkg::OP_INSERT, 32'h8000_0000, 1'b0);
		send_word(ise_pkg::OP_INSERT, 32'h7fff_ffff, 1'b0);
		send_word(ise_pkg::OP_INSERT, 32'h0000_0000, 1'b0);
		send_word(ise_pkg::OP_INSERT, 32'hffff_ffff, 1'b0);
		send_word(ise_pkg::OP_INSERT, 32'hffff_ffff, 1'b1);  // already present
		send_word(ise_pkg::OP_PROBE,  32'h7fff_ffff, 1'b1);  // member, flag ignored
		send_word(ise_pkg::OP_PROBE,  32'h0000_0005, 1'b0);  // nonmember
		send_word(ise_pkg::OP_LIST,   32'h0000_0000, 1'b1);  // difference
		send_word(ise_pkg::OP_PROBE,  32'h0000_0000, 1'b0);
		send_word(ise_pkg::OP_PROBE,  32'h8000_0000, 1'b0);
		send_word(ise_pkg::OP_DELETE, 32'h8000_0000, 1'b0);  // mark of 0 shifts down
		send_word(ise_pkg::OP_LIST,   32'hdead_beef, 1'b1);
		send_word(ise_pkg::OP_LIST,   32'h0000_0001, 1'b0);  // marks cleared by last list
		send_word(ise_pkg::OP_DELETE, 32'h0001_2345, 1'b0);  // absent
		send_word(ise_pkg::OP_INSERT, 32'h55aa_55aa, 1'b1);
		send_word(ise_pkg::OP_DELETE, 32'h7fff_ffff, 1'b1);
		send_word(ise_pkg::OP_DELETE, 32'h0000_0000, 1'b0);
		send_word(ise_pkg::OP_DELETE, 32'hffff_ffff, 1'b0);
		send_word(ise_pkg::OP_DELETE, 32'h55aa_55aa, 1'b0);
		send_word(ise_pkg::OP_LIST,   32'haaaa_5555, 1'b1);  // empty again

		send_random(RAND_PER_PHASE);
		in_idle_pct  = 73;
		out_idle_pct = 32;
		send_random(RAND_PER_PHASE);
		in_idle_pct  = 0;
		out_idle_pct = 0;
		hold_req     = 1'b1;
		send_random(RAND_PER_PHASE);
		in_valid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (board.errors == 0) begin
			$display("PASS integer_set_engine_core");
		end else begin
			$display("FAIL integer_set_engine_core");
		end
		$finish;
	end

endmodule
